[src/uhg_pkg.sv]
`timescale 1ns / 1ps
// Package for the UDP/IP header generator: protocol constants, the records
// that pass between the pipeline stages and the checksum fold. No dependencies.
package uhg_pkg;

  // Field widths
  localparam int ADDR_W = 64;
  localparam int PORT_W = 16;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 17;

  // Header image: 48 bytes, IPv4 left-aligned in the same vector
  localparam int HDR_BYTES_V4 = 28;
  localparam int HDR_BYTES_V6 = 48;
  localparam int HDR_W        = HDR_BYTES_V6 * BYTE_W;
  localparam int CNT_W        = $clog2(HDR_BYTES_V6);

  // Protocol constants
  localparam logic [7:0]  IPV4_VER_IHL = 8'h45;
  localparam logic [7:0]  IPV6_VER     = 8'h60;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  HOP_LIMIT    = 8'd64;
  localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
  localparam logic [15:0] IPV4_HDR_LEN = 16'd20;
  localparam logic [15:0] IPV4_W0      = {IPV4_VER_IHL, 8'h00};
  localparam logic [15:0] IPV4_TTL_PR  = {HOP_LIMIT, PROTO_UDP};

  // Largest payload that fits a 65535-byte IP datagram
  localparam logic [LEN_W-1:0] MAX_PAY_V4 = 17'd65507;
  localparam logic [LEN_W-1:0] MAX_PAY_V6 = 17'd65527;
  localparam logic [LEN_W-1:0] LEN_SAT    = 17'h1FFFF;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  // Packet record captured on the last item
  typedef struct packed {
    logic              v6;
    logic              drop;
    logic [ADDR_W-1:0] sh;
    logic [ADDR_W-1:0] sl;
    logic [ADDR_W-1:0] dh;
    logic [ADDR_W-1:0] dl;
    logic [PORT_W-1:0] sp;
    logic [PORT_W-1:0] dp;
    logic [15:0]       sum;
    logic              odd;
    logic [7:0]        held;
    logic [15:0]       seg;
    logic [15:0]       ident;
  } desc_t;

  // Partial sums after the first checksum stage
  typedef struct packed {
    desc_t       d;
    logic [17:0] a_sh;
    logic [17:0] a_sl;
    logic [17:0] a_dh;
    logic [17:0] a_dl;
    logic [16:0] b_sl;
    logic [16:0] b_dl;
    logic [18:0] misc_u;
    logic [17:0] misc_h;
  } part_t;

  // Record with both checksums, ready for the emitter
  typedef struct packed {
    desc_t       d;
    logic [15:0] ucs;
    logic [15:0] hcs;
  } fin_t;

  // Fold a wide integer sum into a 16-bit ones'-complement sum
  function automatic logic [15:0] fold21(input logic [20:0] n);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, n[15:0]} + {12'd0, n[20:16]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return f2;
  endfunction

endpackage

[src/uhg_if.sv]
`timescale 1ns / 1ps
// Channel interfaces for the UDP/IP header generator: payload input and
// header result. Depends on uhg_pkg.
interface uhg_in_if;
  import uhg_pkg::*;

  logic              valid;
  logic              ready;
  logic              ip_version;
  logic [ADDR_W-1:0] src_addr_hi;
  logic [ADDR_W-1:0] src_addr_lo;
  logic [ADDR_W-1:0] dst_addr_hi;
  logic [ADDR_W-1:0] dst_addr_lo;
  logic [PORT_W-1:0] src_port;
  logic [PORT_W-1:0] dst_port;
  logic [BYTE_W-1:0] payload_byte;
  logic              byte_valid;
  logic              last_item;

  modport source (
    output valid, ip_version, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
           src_port, dst_port, payload_byte, byte_valid, last_item,
    input  ready
  );
  modport sink (
    input  valid, ip_version, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
           src_port, dst_port, payload_byte, byte_valid, last_item,
    output ready
  );
endinterface

interface uhg_out_if;
  import uhg_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] header_byte;
  logic              header_last;
  logic              status;

  modport source (output valid, header_byte, header_last, status, input ready);
  modport sink (input valid, header_byte, header_last, status, output ready);
endinterface

[src/udp_ip_header_generator.sv]
`timescale 1ns / 1ps
// UDP/IP header generator top level: accumulator, checksum pipeline and
// header emitter. Depends on uhg_pkg, uhg_if, uhg_accum, uhg_csum, uhg_emit.
//
// Takes one payload byte per cycle unless stalled and keeps the running
// ones'-complement sum, odd-byte hold and length of the current packet. The
// last item closes the packet: its record passes a two-stage checksum pipeline
// and the header goes out one byte per cycle while the receiver is ready, 28
// bytes for IPv4 and 48 for IPv6, or a single result with status set when the
// payload is too long. The record passes the record register, both checksum
// stages, the header image and the output register before the first header
// byte. Payload bytes of the next packet keep flowing while a header is sent;
// the input stalls, for any item, while a closed packet record is still held
// because the checksum pipeline and the emitter are full, so packets shorter
// than their header run at the output rate. There are no configuration registers.
module udp_ip_header_generator (
  input  logic      clk,
  input  logic      rst_n,
  uhg_in_if.sink    in_ch,
  uhg_out_if.source out_ch
);
  import uhg_pkg::*;

  desc_t desc;
  logic  desc_valid, desc_ready;
  fin_t  fin;
  logic  fin_valid, fin_ready;

  // Accumulate payload and close packets
  uhg_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .desc       (desc),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready)
  );

  // Compute the UDP and IPv4 header checksums
  uhg_csum u_csum (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (desc),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .fin        (fin),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready)
  );

  // Send the header bytes
  uhg_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin       (fin),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .out_ch    (out_ch)
  );

endmodule

[src/uhg_accum.sv]
`timescale 1ns / 1ps
// Payload accumulator: running ones'-complement sum, odd-byte hold, length
// count and identification counter. Depends on uhg_pkg and uhg_if.
module uhg_accum (
  input  logic           clk,
  input  logic           rst_n,
  uhg_in_if.sink         in_ch,
  output uhg_pkg::desc_t desc,
  output logic           desc_valid,
  input  logic           desc_ready
);
  import uhg_pkg::*;

  logic [15:0]      sum_r, sum_nxt, sum_upd;
  logic             odd_r, odd_nxt, odd_upd;
  logic [7:0]       held_r, held_nxt, held_upd;
  logic [LEN_W-1:0] len_r, len_nxt, len_upd;
  logic [15:0]      ident_r, ident_nxt;
  desc_t            desc_r, desc_nxt;
  logic             desc_valid_r, desc_valid_nxt;
  logic [16:0]      pair_sum;
  logic [LEN_W-1:0] max_pay;
  logic             xfer;

  // Stall while the packet record waits for the checksum stage
  assign in_ch.ready = !desc_valid_r || desc_ready;
  assign xfer        = in_ch.valid && in_ch.ready;
  assign desc        = desc_r;
  assign desc_valid  = desc_valid_r;

  // Update the per-packet state with this transfer
  always_comb begin
    sum_upd  = sum_r;
    odd_upd  = odd_r;
    held_upd = held_r;
    len_upd  = len_r;
    pair_sum = {1'b0, sum_r} + {1'b0, held_r, in_ch.payload_byte};
    if (in_ch.byte_valid) begin
      if (odd_r) begin
        sum_upd = pair_sum[15:0] + {15'd0, pair_sum[16]};
        odd_upd = 1'b0;
      end else begin
        held_upd = in_ch.payload_byte;
        odd_upd  = 1'b1;
      end
      if (len_r != LEN_SAT) begin
        len_upd = len_r + 17'd1;
      end
    end
    max_pay = in_ch.ip_version ? MAX_PAY_V6 : MAX_PAY_V4;
  end

  // Next state: hold, advance, or close the packet on the last item
  always_comb begin
    sum_nxt        = sum_r;
    odd_nxt        = odd_r;
    held_nxt       = held_r;
    len_nxt        = len_r;
    ident_nxt      = ident_r;
    desc_nxt       = desc_r;
    desc_valid_nxt = desc_valid_r && !desc_ready;
    if (xfer) begin
      if (in_ch.last_item) begin
        sum_nxt        = '0;
        odd_nxt        = 1'b0;
        held_nxt       = '0;
        len_nxt        = '0;
        ident_nxt      = ident_r + 16'd1;
        desc_valid_nxt = 1'b1;
        desc_nxt.v6    = in_ch.ip_version;
        desc_nxt.drop  = len_upd > max_pay;
        desc_nxt.sh    = in_ch.src_addr_hi;
        desc_nxt.sl    = in_ch.src_addr_lo;
        desc_nxt.dh    = in_ch.dst_addr_hi;
        desc_nxt.dl    = in_ch.dst_addr_lo;
        desc_nxt.sp    = in_ch.src_port;
        desc_nxt.dp    = in_ch.dst_port;
        desc_nxt.sum   = sum_upd;
        desc_nxt.odd   = odd_upd;
        desc_nxt.held  = held_upd;
        desc_nxt.seg   = len_upd[15:0] + UDP_HDR_LEN;
        desc_nxt.ident = ident_r;
      end else begin
        sum_nxt  = sum_upd;
        odd_nxt  = odd_upd;
        held_nxt = held_upd;
        len_nxt  = len_upd;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      odd_r        <= 1'b0;
      held_r       <= '0;
      len_r        <= '0;
      ident_r      <= '0;
      desc_valid_r <= 1'b0;
    end else begin
      sum_r        <= sum_nxt;
      odd_r        <= odd_nxt;
      held_r       <= held_nxt;
      len_r        <= len_nxt;
      ident_r      <= ident_nxt;
      desc_valid_r <= desc_valid_nxt;
    end
  end

  // Packet record
  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

endmodule

[src/uhg_csum.sv]
`timescale 1ns / 1ps
// Two-stage checksum pipeline: partial word sums, then the final sum, fold
// and complement for the UDP and IPv4 header checksums. Depends on uhg_pkg.
module uhg_csum (
  input  logic           clk,
  input  logic           rst_n,
  input  uhg_pkg::desc_t desc,
  input  logic           desc_valid,
  output logic           desc_ready,
  output uhg_pkg::fin_t  fin,
  output logic           fin_valid,
  input  logic           fin_ready
);
  import uhg_pkg::*;

  part_t       s1_r, s1_nxt;
  logic        s1_valid_r;
  fin_t        s2_r, s2_nxt;
  logic        s2_valid_r;
  logic        s1_ready, s2_ready;
  logic [15:0] tot;
  logic [15:0] odd_word;
  logic [20:0] n_u, n_h;
  logic [15:0] f_u, f_h;

  // Sum the four 16-bit words of a 64-bit field
  function automatic logic [17:0] sum4(input logic [63:0] x);
    return {2'b00, x[63:48]} + {2'b00, x[47:32]} + {2'b00, x[31:16]} + {2'b00, x[15:0]};
  endfunction

  // Sum the two 16-bit words of an IPv4 address
  function automatic logic [16:0] sum2(input logic [63:0] x);
    return {1'b0, x[31:16]} + {1'b0, x[15:0]};
  endfunction

  assign s2_ready   = !s2_valid_r || fin_ready;
  assign s1_ready   = !s1_valid_r || s2_ready;
  assign desc_ready = s1_ready;
  assign fin        = s2_r;
  assign fin_valid  = s2_valid_r;

  // Stage 1: partial sums of addresses and the short fields
  always_comb begin
    tot             = desc.seg + IPV4_HDR_LEN;
    odd_word        = desc.odd ? {desc.held, 8'h00} : 16'h0000;
    s1_nxt.d        = desc;
    s1_nxt.a_sh     = sum4(desc.sh);
    s1_nxt.a_sl     = sum4(desc.sl);
    s1_nxt.a_dh     = sum4(desc.dh);
    s1_nxt.a_dl     = sum4(desc.dl);
    s1_nxt.b_sl     = sum2(desc.sl);
    s1_nxt.b_dl     = sum2(desc.dl);
    s1_nxt.misc_u   = {3'd0, desc.sum} + {3'd0, odd_word} + {11'd0, PROTO_UDP}
                    + {3'd0, desc.sp} + {3'd0, desc.dp} + {2'd0, desc.seg, 1'b0};
    s1_nxt.misc_h   = {2'd0, IPV4_W0} + {2'd0, tot} + {2'd0, desc.ident}
                    + {2'd0, IPV4_TTL_PR};
  end

  // Stage 2: total, fold, complement; a zero UDP checksum goes out as all ones
  always_comb begin
    if (s1_r.d.v6) begin
      n_u = {3'd0, s1_r.a_sh} + {3'd0, s1_r.a_sl} + {3'd0, s1_r.a_dh}
          + {3'd0, s1_r.a_dl} + {2'd0, s1_r.misc_u};
    end else begin
      n_u = {4'd0, s1_r.b_sl} + {4'd0, s1_r.b_dl} + {2'd0, s1_r.misc_u};
    end
    n_h        = {3'd0, s1_r.misc_h} + {4'd0, s1_r.b_sl} + {4'd0, s1_r.b_dl};
    f_u        = fold21(n_u);
    f_h        = fold21(n_h);
    s2_nxt.d   = s1_r.d;
    s2_nxt.ucs = (f_u == 16'hFFFF) ? 16'hFFFF : ~f_u;
    s2_nxt.hcs = ~f_h;
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= desc_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage data
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

[src/uhg_emit.sv]
`timescale 1ns / 1ps
// Header emitter: builds the header image into a shift register and sends
// it one byte per transfer through the output register. Depends on uhg_pkg, uhg_if.
module uhg_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  uhg_pkg::fin_t fin,
  input  logic          fin_valid,
  output logic          fin_ready,
  uhg_out_if.source     out_ch
);
  import uhg_pkg::*;

  logic [HDR_W-1:0]  hdr_r, hdr_nxt, hdr_img;
  logic [CNT_W-1:0]  rem_r, rem_nxt, rem_load;
  logic              active_r, active_nxt;
  logic              drop_r, drop_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              os_r, os_nxt;
  logic              out_free, step, ld;
  logic [15:0]       tot;

  assign out_free  = !ov_r || out_ch.ready;
  assign step      = active_r && out_free;
  assign fin_ready = !active_r || (step && rem_r == '0);
  assign ld        = fin_valid && fin_ready;

  assign out_ch.valid       = ov_r;
  assign out_ch.header_byte = ob_r;
  assign out_ch.header_last = ol_r;
  assign out_ch.status      = os_r;

  // Build the header image for the incoming record
  always_comb begin
    tot = fin.d.seg + IPV4_HDR_LEN;
    if (fin.d.drop) begin
      hdr_img  = '0;
      rem_load = '0;
    end else if (fin.d.v6) begin
      hdr_img  = {IPV6_VER, 24'h0, fin.d.seg, PROTO_UDP, HOP_LIMIT,
                  fin.d.sh, fin.d.sl, fin.d.dh, fin.d.dl,
                  fin.d.sp, fin.d.dp, fin.d.seg, fin.ucs};
      rem_load = CNT_W'(HDR_BYTES_V6 - 1);
    end else begin
      hdr_img  = {IPV4_W0, tot, fin.d.ident, 16'h0000, IPV4_TTL_PR, fin.hcs,
                  fin.d.sl[31:0], fin.d.dl[31:0],
                  fin.d.sp, fin.d.dp, fin.d.seg, fin.ucs,
                  {(HDR_BYTES_V6 - HDR_BYTES_V4) * BYTE_W{1'b0}}};
      rem_load = CNT_W'(HDR_BYTES_V4 - 1);
    end
  end

  // Shift out one byte per transfer, load the next record on the last byte
  always_comb begin
    hdr_nxt    = hdr_r;
    rem_nxt    = rem_r;
    active_nxt = active_r;
    drop_nxt   = drop_r;
    ov_nxt     = ov_r && !out_ch.ready;
    ob_nxt     = ob_r;
    ol_nxt     = ol_r;
    os_nxt     = os_r;
    if (step) begin
      ov_nxt  = 1'b1;
      ob_nxt  = hdr_r[HDR_W-1 -: BYTE_W];
      ol_nxt  = (rem_r == '0);
      os_nxt  = drop_r ? STATUS_DROP : STATUS_OK;
      hdr_nxt = {hdr_r[HDR_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
      rem_nxt = rem_r - CNT_W'(1);
      if (rem_r == '0) begin
        active_nxt = 1'b0;
      end
    end
    if (ld) begin
      hdr_nxt    = hdr_img;
      rem_nxt    = rem_load;
      drop_nxt   = fin.d.drop;
      active_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Header image and output payload
  always_ff @(posedge clk) begin
    hdr_r  <= hdr_nxt;
    rem_r  <= rem_nxt;
    drop_r <= drop_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    os_r   <= os_nxt;
  end

endmodule

[tb/sv/udp_ip_header_generator_tb.sv]
`timescale 1ns / 1ps
// Testbench for udp_ip_header_generator: streams UDP payloads in, predicts the
// IPv4/IPv6 and UDP header bytes and compares every header result.
// Depends on uhg_pkg, uhg_if and the udp_ip_header_generator RTL.
module udp_ip_header_generator_tb;
  import uhg_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 108;
  localparam int MAX_REPORTS  = 10;

  localparam logic [ADDR_W-1:0] A_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [ADDR_W-1:0] A_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] A_ALT   = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [ADDR_W-1:0] A_ALT_N = 64'h5555_5555_5555_5555;

  // Header of an empty IPv4 packet right after reset: all addresses and ports
  // zero, identification 0
  localparam logic [HDR_BYTES_V4*8-1:0] EMPTY_V4_HDR =
    224'h4500_001C_0000_0000_4011_7AD2_0000_0000_0000_0000_0000_0000_0008_FFDE;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_DROP, CHK_EMPTY_V4} chk_e;

  typedef struct packed {
    logic              v6;
    logic [ADDR_W-1:0] sh;
    logic [ADDR_W-1:0] sl;
    logic [ADDR_W-1:0] dh;
    logic [ADDR_W-1:0] dl;
    logic [PORT_W-1:0] sp;
    logic [PORT_W-1:0] dp;
    logic [BYTE_W-1:0] pbyte;
    logic              bvalid;
    logic              last;
  } pay_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] hbyte;
    logic              hlast;
    logic              status;
  } hdr_res_t;

  // One packet of stimulus
  typedef struct {
    logic              v6;
    logic [ADDR_W-1:0] sh;
    logic [ADDR_W-1:0] sl;
    logic [ADDR_W-1:0] dh;
    logic [ADDR_W-1:0] dl;
    logic [PORT_W-1:0] sp;
    logic [PORT_W-1:0] dp;
    int unsigned       len;
    fill_e             fill;
    bit                tail_inv;
    bit                noise;
    bit                scramble;
    bit                zero_csum;
    chk_e              chk;
  } pkt_row_t;

  logic clk;
  logic rst_n;

  uhg_in_if  in_ch ();
  uhg_out_if out_ch ();

  udp_ip_header_generator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state of the packet in progress
  logic [15:0]      pay_sum;
  logic             odd_pend;
  logic [7:0]       odd_byte;
  logic [LEN_W-1:0] pay_len;
  logic [15:0]      next_ident;

  hdr_res_t    built_hdr_q[$];
  hdr_res_t    pending_hdr_q[$];
  pkt_row_t    dir_rows[$];
  int          src_idle_pct = 21;
  int          rcv_idle_pct = 56;
  bit          hold_req = 1'b0;
  int          mismatches = 0;
  int          stall_cycles = 0;
  int unsigned items_sent = 0;

  // Ones'-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [15:0] oc_add64(input logic [15:0] s, input logic [63:0] v);
    logic [15:0] r;
    int          k;
    r = s;
    for (k = 3; k >= 0; k--) r = oc_add(r, v[16*k +: 16]);
    return r;
  endfunction

  // UDP sum over payload, pseudo-header and UDP header, before inversion
  function automatic logic [15:0] udp_pseudo_sum(input pay_item_t it);
    logic [15:0]      s;
    logic [LEN_W-1:0] seg;
    seg = pay_len + LEN_W'(UDP_HDR_LEN);
    s = pay_sum;
    if (odd_pend) s = oc_add(s, {odd_byte, 8'h00});
    if (it.v6) begin
      s = oc_add64(s, it.sh);
      s = oc_add64(s, it.sl);
      s = oc_add64(s, it.dh);
      s = oc_add64(s, it.dl);
      s = oc_add(s, {15'd0, seg[16]});
      s = oc_add(s, seg[15:0]);
      s = oc_add(s, {8'h00, PROTO_UDP});
    end else begin
      s = oc_add(s, it.sl[31:16]);
      s = oc_add(s, it.sl[15:0]);
      s = oc_add(s, it.dl[31:16]);
      s = oc_add(s, it.dl[15:0]);
      s = oc_add(s, {8'h00, PROTO_UDP});
      s = oc_add(s, seg[15:0]);
    end
    s = oc_add(s, it.sp);
    s = oc_add(s, it.dp);
    return oc_add(s, seg[15:0]);
  endfunction

  // Append one expected result to the queue of results still to come
  function automatic void expect_res(input hdr_res_t r);
    pending_hdr_q.insert(pending_hdr_q.size(), r);
  endfunction

  function automatic void add_row(input pkt_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    built_hdr_q.insert(built_hdr_q.size(), '{hbyte: b, hlast: 1'b0, status: STATUS_OK});
  endfunction

  function automatic void put16(input logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endfunction

  function automatic void put64(input logic [63:0] v);
    int k;
    for (k = 7; k >= 0; k--) put_byte(v[8*k +: 8]);
  endfunction

  // Absorb one accepted item; on a last item build its header in built_hdr_q
  function automatic void build_header(input pay_item_t it);
    logic [15:0]      ident;
    logic [15:0]      ucs;
    logic [15:0]      tot;
    logic [15:0]      hsum;
    logic [LEN_W-1:0] seg;
    logic [LEN_W-1:0] max_pay;
    built_hdr_q.delete();
    if (it.bvalid) begin
      if (odd_pend) begin
        pay_sum = oc_add(pay_sum, {odd_byte, it.pbyte});
        odd_pend = 1'b0;
      end else begin
        odd_byte = it.pbyte;
        odd_pend = 1'b1;
      end
      if (pay_len != LEN_SAT) pay_len = pay_len + LEN_W'(1);
    end
    if (!it.last) return;

    ident = next_ident;
    next_ident = next_ident + 16'd1;
    max_pay = it.v6 ? MAX_PAY_V6 : MAX_PAY_V4;
    if (pay_len > max_pay) begin
      built_hdr_q.insert(built_hdr_q.size(),
                         '{hbyte: 8'h00, hlast: 1'b1, status: STATUS_DROP});
    end else begin
      seg = pay_len + LEN_W'(UDP_HDR_LEN);
      ucs = ~udp_pseudo_sum(it);
      if (ucs == 16'h0000) ucs = 16'hFFFF;
      if (it.v6) begin
        put_byte(IPV6_VER);
        put_byte(8'h00);
        put16(16'h0000);
        put16(seg[15:0]);
        put_byte(PROTO_UDP);
        put_byte(HOP_LIMIT);
        put64(it.sh);
        put64(it.sl);
        put64(it.dh);
        put64(it.dl);
      end else begin
        tot = IPV4_HDR_LEN + seg[15:0];
        hsum = oc_add(16'h0000, IPV4_W0);
        hsum = oc_add(hsum, tot);
        hsum = oc_add(hsum, ident);
        hsum = oc_add(hsum, IPV4_TTL_PR);
        hsum = oc_add(hsum, it.sl[31:16]);
        hsum = oc_add(hsum, it.sl[15:0]);
        hsum = oc_add(hsum, it.dl[31:16]);
        hsum = oc_add(hsum, it.dl[15:0]);
        put_byte(IPV4_VER_IHL);
        put_byte(8'h00);
        put16(tot);
        put16(ident);
        put16(16'h0000);
        put_byte(HOP_LIMIT);
        put_byte(PROTO_UDP);
        put16(~hsum);
        put16(it.sl[31:16]);
        put16(it.sl[15:0]);
        put16(it.dl[31:16]);
        put16(it.dl[15:0]);
      end
      put16(it.sp);
      put16(it.dp);
      put16(seg[15:0]);
      put16(ucs);
      built_hdr_q[built_hdr_q.size()-1].hlast = 1'b1;
    end

    // Drop per-packet state, keep the identification
    pay_sum = 16'h0000;
    odd_pend = 1'b0;
    odd_byte = 8'h00;
    pay_len = '0;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(7))
      0: return A_ZERO;
      1: return A_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] rand_port();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic pay_item_t rand_item();
    pay_item_t it;
    it.v6 = 1'($urandom_range(1));
    it.sh = rand_addr();
    it.sl = rand_addr();
    it.dh = rand_addr();
    it.dl = rand_addr();
    it.sp = rand_port();
    it.dp = rand_port();
    it.pbyte = 8'($urandom_range(255));
    it.bvalid = 1'b1;
    it.last = 1'b0;
    return it;
  endfunction

  function automatic pkt_row_t mk_row(
    input logic v6, input logic [63:0] sh, input logic [63:0] sl,
    input logic [63:0] dh, input logic [63:0] dl, input logic [15:0] sp,
    input logic [15:0] dp, input int unsigned len, input fill_e fill,
    input bit tail_inv, input bit noise, input bit scramble, input bit zero_csum,
    input chk_e chk);
    pkt_row_t r;
    r.v6 = v6;
    r.sh = sh;
    r.sl = sl;
    r.dh = dh;
    r.dl = dl;
    r.sp = sp;
    r.dp = dp;
    r.len = len;
    r.fill = fill;
    r.tail_inv = tail_inv;
    r.noise = noise;
    r.scramble = scramble;
    r.zero_csum = zero_csum;
    r.chk = chk;
    return r;
  endfunction

  // Mostly short packets; a few up to 64 bytes
  function automatic pkt_row_t rand_row();
    pkt_row_t    r;
    int unsigned pick;
    r = mk_row(1'($urandom_range(1)), rand_addr(), rand_addr(), rand_addr(), rand_addr(),
               rand_port(), rand_port(), 0, FILL_RAND, 1'b0, 1'($urandom_range(1)),
               ($urandom_range(9) < 7), ($urandom_range(11) == 0), CHK_MODEL);
    pick = $urandom_range(99);
    if (pick < 10) r.len = 0;
    else if (pick < 85) r.len = $urandom_range(12, 1);
    else r.len = $urandom_range(64, 13);
    r.tail_inv = r.zero_csum || ($urandom_range(3) == 0);
    return r;
  endfunction

  // Offer one item, wait for its transfer, then predict
  task automatic drive_item(input pay_item_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.ip_version   <= it.v6;
    in_ch.src_addr_hi  <= it.sh;
    in_ch.src_addr_lo  <= it.sl;
    in_ch.dst_addr_hi  <= it.dh;
    in_ch.dst_addr_lo  <= it.dl;
    in_ch.src_port     <= it.sp;
    in_ch.dst_port     <= it.dp;
    in_ch.payload_byte <= it.pbyte;
    in_ch.byte_valid   <= it.bvalid;
    in_ch.last_item    <= it.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    build_header(it);
    if (it.bvalid || it.last) items_sent++;
  endtask

  task automatic send_packet(input pkt_row_t r);
    pay_item_t   it;
    pay_item_t   hdr;
    int unsigned i;
    int          k;
    hdr = rand_item();
    hdr.v6 = r.v6;
    hdr.sh = r.sh;
    hdr.sl = r.sl;
    hdr.dh = r.dh;
    hdr.dl = r.dl;
    hdr.sp = r.sp;
    hdr.dp = r.dp;

    // Payload bytes; ignored items and scrambled header fields in between
    for (i = 0; i < r.len; i++) begin
      if (r.noise && $urandom_range(9) == 0) begin
        it = rand_item();
        it.bvalid = 1'b0;
        drive_item(it);
      end
      it = r.scramble ? rand_item() : hdr;
      it.last = !r.tail_inv && (i == r.len - 1);
      if (it.last) it = hdr;
      case (r.fill)
        FILL_ZERO: it.pbyte = 8'h00;
        FILL_ONES: it.pbyte = 8'hFF;
        default:   it.pbyte = 8'($urandom_range(255));
      endcase
      it.bvalid = 1'b1;
      it.last = !r.tail_inv && (i == r.len - 1);
      drive_item(it);
    end

    // Close with an item that carries no byte
    if (r.tail_inv || r.len == 0) begin
      it = hdr;
      it.pbyte = 8'($urandom_range(255));
      it.bvalid = 1'b0;
      it.last = 1'b1;
      // Pick the destination port that brings the UDP checksum to zero
      if (r.zero_csum) begin
        it.dp = 16'h0000;
        it.dp = ~udp_pseudo_sum(it);
      end
      drive_item(it);
    end

    case (r.chk)
      CHK_DROP: begin
        expect_res('{hbyte: 8'h00, hlast: 1'b1, status: STATUS_DROP});
      end
      CHK_EMPTY_V4: begin
        for (k = 0; k < HDR_BYTES_V4; k++) begin
          expect_res('{hbyte: EMPTY_V4_HDR[8*(HDR_BYTES_V4-1-k) +: 8],
                       hlast: (k == HDR_BYTES_V4 - 1), status: STATUS_OK});
        end
      end
      default: begin
        foreach (built_hdr_q[j]) expect_res(built_hdr_q[j]);
      end
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Compare every result transfer with the oldest expected header byte
  always @(posedge clk) begin
    hdr_res_t got;
    hdr_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{hbyte: out_ch.header_byte, hlast: out_ch.header_last, status: out_ch.status};
      if (pending_hdr_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result byte=%h last=%b status=%b",
                   $realtime, got.hbyte, got.hlast, got.status);
        end
      end else begin
        want = pending_hdr_q.pop_front();
        if (got.hbyte !== want.hbyte || got.hlast !== want.hlast ||
            got.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: byte exp=%h got=%h  last exp=%b got=%b  status exp=%b got=%b",
                     $realtime, want.hbyte, got.hbyte, want.hlast, got.hlast,
                     want.status, got.status);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int ph;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.ip_version   = 1'b0;
    in_ch.src_addr_hi  = '0;
    in_ch.src_addr_lo  = '0;
    in_ch.dst_addr_hi  = '0;
    in_ch.dst_addr_lo  = '0;
    in_ch.src_port     = '0;
    in_ch.dst_port     = '0;
    in_ch.payload_byte = '0;
    in_ch.byte_valid   = 1'b0;
    in_ch.last_item    = 1'b0;
    pay_sum    = 16'h0000;
    odd_pend   = 1'b0;
    odd_byte   = 8'h00;
    pay_len    = '0;
    next_ident = 16'h0000;

    // Directed packets: v6, src hi/lo, dst hi/lo, ports, then length, fill,
    // closing item without byte, noise, scrambled fields, zero checksum, check
    add_row(mk_row(1'b0, A_ZERO, A_ZERO, A_ZERO, A_ZERO, 16'h0000, 16'h0000,
      0, FILL_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, CHK_EMPTY_V4));
    add_row(mk_row(1'b1, A_ONES, A_ONES, A_ONES, A_ONES, 16'hFFFF, 16'hFFFF,
      0, FILL_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, CHK_MODEL));
    add_row(mk_row(1'b0, A_ZERO, A_ONES, A_ZERO, A_ONES, 16'h0000, 16'h0000,
      1, FILL_ONES, 1'b0, 1'b0, 1'b0, 1'b0, CHK_MODEL));
    add_row(mk_row(1'b0, A_ZERO, 64'hC0A8_0001, A_ZERO, 64'h0A00_0002,
      16'h1234, 16'h0035, 2, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b0, CHK_MODEL));
    add_row(mk_row(1'b0, A_ONES, A_ONES, A_ONES, A_ONES, 16'hFFFF, 16'h0000,
      3, FILL_RAND, 1'b1, 1'b0, 1'b0, 1'b1, CHK_MODEL));
    add_row(mk_row(1'b1, A_ALT, A_ALT_N, A_ALT_N, A_ALT, 16'h8000, 16'h0000,
      4, FILL_RAND, 1'b1, 1'b0, 1'b0, 1'b1, CHK_MODEL));
    add_row(mk_row(1'b0, A_ALT, A_ALT_N, A_ALT, A_ALT_N, 16'hAAAA, 16'h5555,
      5, FILL_RAND, 1'b1, 1'b1, 1'b1, 1'b0, CHK_MODEL));
    add_row(mk_row(1'b1, A_ALT_N, A_ALT, A_ONES, A_ZERO, 16'h5555, 16'hAAAA,
      7, FILL_RAND, 1'b0, 1'b1, 1'b1, 1'b0, CHK_MODEL));
    // Short packets with mixed addresses and ports
    add_row(mk_row(1'b0, A_ZERO, 64'hC0A8_0101, A_ZERO, 64'hC0A8_01FE,
      16'h3039, 16'hD431, 2, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b0, CHK_MODEL));
    add_row(mk_row(1'b1, A_ONES, A_ZERO, A_ZERO, A_ONES, 16'h0000, 16'hFFFF,
      1, FILL_ONES, 1'b0, 1'b0, 1'b0, 1'b0, CHK_MODEL));
    add_row(mk_row(1'b0, A_ONES, A_ONES, A_ONES, A_ONES, 16'hFFFF, 16'hFFFF,
      0, FILL_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, CHK_MODEL));
    add_row(mk_row(1'b1, A_ALT, A_ALT, A_ALT_N, A_ALT_N, 16'h00FF, 16'hFF00,
      6, FILL_RAND, 1'b0, 1'b1, 1'b0, 1'b0, CHK_MODEL));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_packet(dir_rows[i]);

    // Random packets in three idling phases
    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle_pct = 56;
        rcv_idle_pct = 21;
        hold_req = 1'b1;
      end else if (ph == 2) begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        // Hold the input until every header has gone out
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_hdr_q.size() != 0);
      end
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) send_packet(rand_row());
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_hdr_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_hdr_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
